### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

### src/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants of the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int LEN_W  = 32;
    localparam int BYTE_W = 8;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [BYTE_W-1:0] byte_t;

    localparam len_t MAX_LEN_RESET = len_t'(32'h0100_0000);
    localparam logic [1:0] HDR_LAST = 2'd3;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        byte_t rx_byte;
        logic  chunk_end;
    } lpd_item_t;

    typedef struct packed {
        kind_t kind;
        byte_t payload_byte;
        logic  first_of_frame;
        logic  last_of_frame;
        len_t  frame_length;
    } lpd_result_t;

endpackage

### src/lpd_in_if.sv
// ----------------------------------------------------------------------------
// lpd_in_if
// Byte stream channel: one received byte and its chunk-end mark.
// ----------------------------------------------------------------------------
interface lpd_in_if;
    import lpd_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;
    logic  chunk_end;

    modport source (output valid, output rx_byte, output chunk_end, input ready);
    modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

### src/lpd_out_if.sv
// ----------------------------------------------------------------------------
// lpd_out_if
// Result channel: payload bytes, empty-frame and oversize-error results.
// ----------------------------------------------------------------------------
interface lpd_out_if;
    import lpd_pkg::*;

    logic  valid;
    logic  ready;
    kind_t kind;
    byte_t payload_byte;
    logic  first_of_frame;
    logic  last_of_frame;
    len_t  frame_length;

    modport source (
        output valid, output kind, output payload_byte, output first_of_frame,
        output last_of_frame, output frame_length, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input first_of_frame,
        input last_of_frame, input frame_length, output ready
    );
endinterface

### src/lpd_in_stage.sv
// ----------------------------------------------------------------------------
// lpd_in_stage
// Input register: holds one byte transaction until the parser takes it.
// ----------------------------------------------------------------------------
module lpd_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    lpd_in_if.sink             in_ch,
    input  logic               take,
    output logic               item_valid,
    output lpd_pkg::lpd_item_t item
);
    import lpd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    lpd_item_t item_reg;
    logic      accept;

    assign in_ch.ready = !valid_reg || take;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.rx_byte   <= in_ch.rx_byte;
            item_reg.chunk_end <= in_ch.chunk_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

### src/lpd_parser.sv
// ----------------------------------------------------------------------------
// lpd_parser
// Frame state and per-byte decision: header assembly, payload cut-through,
// empty frames, oversize error and discard to chunk end.
// ----------------------------------------------------------------------------
module lpd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  lpd_pkg::lpd_item_t   item,
    input  lpd_pkg::len_t        max_len,
    output logic                 res_valid,
    output lpd_pkg::lpd_result_t res
);
    import lpd_pkg::*;

    logic [1:0] hdr_cnt_reg,   hdr_cnt_next;
    len_t       acc_reg,       acc_next;
    len_t       remain_reg,    remain_next;
    logic       in_payload_reg, in_payload_next;
    logic       discard_reg,   discard_next;
    logic       start_reg,     start_next;
    len_t       hdr_len;
    logic       last;

    assign hdr_len = {acc_reg[LEN_W-BYTE_W-1:0], item.rx_byte};
    assign last    = (remain_reg[LEN_W-1:1] == '0);

    always_comb
    begin
        hdr_cnt_next    = hdr_cnt_reg;
        acc_next        = acc_reg;
        remain_next     = remain_reg;
        in_payload_next = in_payload_reg;
        discard_next    = discard_reg;
        start_next      = start_reg;
        res_valid       = 1'b0;
        res.kind           = KIND_PAYLOAD;
        res.payload_byte   = '0;
        res.first_of_frame = 1'b0;
        res.last_of_frame  = 1'b0;
        res.frame_length   = acc_reg;

        if (discard_reg)
        begin
            if (item.chunk_end)
            begin
                discard_next = 1'b0;
                hdr_cnt_next = '0;
                acc_next     = '0;
            end
        end
        else if (in_payload_reg)
        begin
            res_valid          = 1'b1;
            res.payload_byte   = item.rx_byte;
            res.first_of_frame = start_reg;
            res.last_of_frame  = last;
            start_next         = 1'b0;
            if (last)
            begin
                remain_next     = '0;
                in_payload_next = 1'b0;
                start_next      = 1'b1;
                hdr_cnt_next    = '0;
            end
            else
                remain_next = remain_reg - len_t'(1);
        end
        else if (hdr_cnt_reg != HDR_LAST)
        begin
            acc_next     = hdr_len;
            hdr_cnt_next = hdr_cnt_reg + 2'd1;
        end
        else
        begin
            hdr_cnt_next = '0;
            start_next   = 1'b1;
            if (hdr_len > max_len)
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_ERROR;
                res.frame_length = hdr_len;
                discard_next     = !item.chunk_end;
                acc_next         = '0;
            end
            else if (hdr_len == '0)
            begin
                res_valid          = 1'b1;
                res.kind           = KIND_EMPTY;
                res.first_of_frame = 1'b1;
                res.last_of_frame  = 1'b1;
                res.frame_length   = '0;
                acc_next           = '0;
            end
            else
            begin
                acc_next        = hdr_len;
                remain_next     = hdr_len;
                in_payload_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg    <= '0;
            acc_reg        <= '0;
            remain_reg     <= '0;
            in_payload_reg <= 1'b0;
            discard_reg    <= 1'b0;
            start_reg      <= 1'b1;
        end
        else if (fire)
        begin
            hdr_cnt_reg    <= hdr_cnt_next;
            acc_reg        <= acc_next;
            remain_reg     <= remain_next;
            in_payload_reg <= in_payload_next;
            discard_reg    <= discard_next;
            start_reg      <= start_next;
        end
    end
endmodule

### src/lpd_out_stage.sv
// ----------------------------------------------------------------------------
// lpd_out_stage
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module lpd_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  lpd_pkg::lpd_result_t res,
    output logic                 can_accept,
    lpd_out_if.source            out_ch
);
    import lpd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    lpd_result_t res_reg;

    assign can_accept = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ch.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.kind           = res_reg.kind;
    assign out_ch.payload_byte   = res_reg.payload_byte;
    assign out_ch.first_of_frame = res_reg.first_of_frame;
    assign out_ch.last_of_frame  = res_reg.last_of_frame;
    assign out_ch.frame_length   = res_reg.frame_length;
endmodule

### src/length_prefix_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_core
// Splits a byte stream of 4-byte big-endian length headers and payloads.
// ----------------------------------------------------------------------------
// in_ch carries one byte per transaction plus a chunk-end mark. out_ch carries
// one result per payload byte (with first/last marks and the frame length),
// one per zero-length header, and one per oversize header. Header bytes and
// bytes dropped after an oversize header up to the chunk end give no result.
// Throughput is one byte per cycle while out_ch does not stall: the input
// register, the parser logic and the result register each take a new byte.
// A byte passes the input register, the parser logic, then the result register.
// When out_ch stalls with a result waiting, the parser and the result register
// hold; in_ch.ready stays high only while the input register is empty, so at
// most one more byte is taken until the result is taken.
// The user writes max_payload_len through cfg_we/cfg_wdata only while idle;
// the block does not enforce this. It is compared at each completed header.
// Reset clears both stages, returns the parser to header search and sets
// max_payload_len to 16 MiB.
// ----------------------------------------------------------------------------
module length_prefix_deframer_core (
    input  logic          clk,
    input  logic          rst_n,
    lpd_in_if.sink        in_ch,
    lpd_out_if.source     out_ch,
    input  logic          cfg_we,
    input  lpd_pkg::len_t cfg_wdata
);
    import lpd_pkg::*;

    len_t        max_len_reg;
    logic        item_valid;
    lpd_item_t   item;
    logic        fire;
    logic        can_accept;
    logic        res_valid;
    lpd_result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_we)
            max_len_reg <= cfg_wdata;
    end

    assign fire = item_valid && can_accept;

    lpd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    lpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    lpd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire && res_valid),
        .res        (res),
        .can_accept (can_accept),
        .out_ch     (out_ch)
    );
endmodule

### src/lpd_checker.sv
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level checks on the result channel of the deframer core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpd_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input logic [1:0]    kind,
    input lpd_pkg::byte_t payload_byte,
    input logic          first_of_frame,
    input logic          last_of_frame,
    input lpd_pkg::len_t frame_length
);
    import lpd_pkg::*;

    `ASSERT_NEXT(a_valid_held, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_payload_held, clk, rst_n, out_valid && !out_ready,
        $stable(kind) && $stable(payload_byte) && $stable(frame_length))
    `ASSERT_IMPL(a_error_unmarked, clk, rst_n, out_valid && kind == KIND_ERROR,
        !first_of_frame && !last_of_frame && payload_byte == '0)
    `ASSERT_IMPL(a_empty_marked, clk, rst_n, out_valid && kind == KIND_EMPTY,
        first_of_frame && last_of_frame && frame_length == '0 && payload_byte == '0)
endmodule

bind length_prefix_deframer_core lpd_checker u_lpd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .kind           (out_ch.kind),
    .payload_byte   (out_ch.payload_byte),
    .first_of_frame (out_ch.first_of_frame),
    .last_of_frame  (out_ch.last_of_frame),
    .frame_length   (out_ch.frame_length)
);
